>>> src/qmr_pkg.sv
package qmr_pkg;

  localparam int FRAC_BITS = 30;
  localparam int DW        = 32;
  localparam int OPW       = DW + 1;
  localparam int PRW       = 2 * OPW;
  localparam int NW        = PRW - FRAC_BITS + 1;
  localparam int SW        = (NW + 2 > OPW) ? NW + 2 : OPW;

  localparam logic signed [PRW-1:0] HALF =
    {{(PRW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

  // bit n set: term p[n]*q[k^n] is subtracted in component k
  localparam logic [3:0] NEG_MASK [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  localparam logic [2:0] MODE_MUL     = 3'd0;
  localparam logic [2:0] MODE_CONJ_A  = 3'd1;
  localparam logic [2:0] MODE_CONJ_B  = 3'd2;
  localparam logic [2:0] MODE_ROT     = 3'd3;
  localparam logic [2:0] MODE_ROT_INV = 3'd4;

  typedef logic [3:0][OPW-1:0] quat_t;
  typedef logic [3:0][DW-1:0]  res_t;

  typedef struct packed {
    logic [2:0] mode;
    quat_t      ac;
    res_t       res;
    logic       sat;
  } side_t;

endpackage

>>> src/qmr_qmul.sv
module qmr_qmul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qmr_pkg::quat_t p_i,
  input  qmr_pkg::quat_t q_i,
  input  logic           want_w_i,
  input  qmr_pkg::side_t side_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qmr_pkg::res_t  r_o,
  output logic           sat_o,
  output qmr_pkg::side_t side_o
);
  import qmr_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [PRW-1:0] prod_d [4][4];
  logic signed [PRW-1:0] prod_q [4][4];
  logic signed [PRW-1:0] shf    [4][4];
  logic signed [NW-1:0]  trunc  [4][4];
  logic signed [NW-1:0]  rnd_d  [4][4];
  logic signed [NW-1:0]  rnd_q  [4][4];
  logic signed [SW-1:0]  sum    [4];
  res_t                  r_d;
  res_t                  r_q;
  logic                  sat_d;
  logic                  sat_q;
  logic                  want1_q;
  logic                  want2_q;
  side_t                 side1_q;
  side_t                 side2_q;
  side_t                 side3_q;

  always_comb begin
    rdy[2] = !vld_q[2] || out_ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];
  assign r_o         = r_q;
  assign sat_o       = sat_q;
  assign side_o      = side3_q;

  // partial products, component k takes p[n] * q[k ^ n]
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int n = 0; n < 4; n++) begin
        prod_d[k][n] = $signed(p_i[n]) * $signed(q_i[2'(k ^ n)]);
      end
    end
  end

  // round to nearest and apply term sign
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int n = 0; n < 4; n++) begin
        shf[k][n]   = (prod_q[k][n] + HALF) >>> FRAC_BITS;
        trunc[k][n] = NW'(shf[k][n]);
        rnd_d[k][n] = NEG_MASK[k][n] ? -trunc[k][n] : trunc[k][n];
      end
    end
  end

  // sum and clip; component 0 is zeroed when want_w is low
  always_comb begin
    sat_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sum[k] = SW'(rnd_q[k][0]) + SW'(rnd_q[k][1]) + SW'(rnd_q[k][2]) + SW'(rnd_q[k][3]);
      if (k == 0 && !want2_q) begin
        r_d[k] = '0;
      end else if (sum[k] > SAT_MAX) begin
        r_d[k] = DW'(SAT_MAX);
        sat_d  = 1'b1;
      end else if (sum[k] < SAT_MIN) begin
        r_d[k] = DW'(SAT_MIN);
        sat_d  = 1'b1;
      end else begin
        r_d[k] = DW'(sum[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (rdy[2]) begin
        vld_q[2] <= vld_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      prod_q  <= prod_d;
      want1_q <= want_w_i;
      side1_q <= side_i;
    end
    if (rdy[1] && vld_q[0]) begin
      rnd_q   <= rnd_d;
      want2_q <= want1_q;
      side2_q <= side1_q;
    end
    if (rdy[2] && vld_q[1]) begin
      r_q     <= r_d;
      sat_q   <= sat_d;
      side3_q <= side2_q;
    end
  end

endmodule

>>> src/quaternion_multiply_rotate.sv
// an accepted item passes the input register, then both multipliers, then the output register
// throughput: one transaction per cycle while m_tready_i is high, no gaps between items
// the two quaternion multipliers are 3-stage pipelines; input and output are registered
// stalls are absorbed stage by stage, an empty stage keeps accepting
// reset (rst_ni low, asynchronous) clears all valid bits, data registers are not reset
module quaternion_multiply_rotate (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [255:0] s_tdata_i,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [2:0]   s_tuser_i,  // mode
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [127:0] m_tdata_o,  // r_w, r_x, r_y, r_z
  output logic [0:0]   m_tuser_o   // saturated
);
  import qmr_pkg::*;

  quat_t      a;
  quat_t      b;
  quat_t      ac;
  quat_t      bc;
  quat_t      v;
  quat_t      p0_d;
  quat_t      q0_d;
  side_t      side0_d;

  logic       s0_vld_q;
  quat_t      s0_p_q;
  quat_t      s0_q_q;
  side_t      s0_side_q;
  logic       s0_rdy;

  logic       u1_in_ready;
  logic       u1_out_valid;
  res_t       u1_r;
  logic       u1_sat;
  side_t      u1_side;

  quat_t      t;
  quat_t      p2;
  quat_t      q2;
  side_t      side2;

  logic       u2_in_ready;
  logic       u2_out_valid;
  res_t       u2_r;
  logic       u2_sat;
  side_t      u2_side;

  logic       out_vld_q;
  logic       out_rdy;
  res_t       out_r_d;
  res_t       out_r_q;
  logic       out_sat_d;
  logic       out_sat_q;
  logic [2:0] out_mode_q;

  // unpack and form conjugates at full width
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i]  = {s_tdata_i[32*i+31], s_tdata_i[32*i +: 32]};
      b[i]  = {s_tdata_i[128+32*i+31], s_tdata_i[128+32*i +: 32]};
      ac[i] = (i == 0) ? a[i] : OPW'(-$signed(a[i]));
      bc[i] = (i == 0) ? b[i] : OPW'(-$signed(b[i]));
      v[i]  = (i == 0) ? '0 : b[i];
    end
  end

  always_comb begin
    case (s_tuser_i)
      MODE_MUL: begin
        p0_d = a;
        q0_d = b;
      end
      MODE_CONJ_A: begin
        p0_d = ac;
        q0_d = b;
      end
      MODE_CONJ_B: begin
        p0_d = a;
        q0_d = bc;
      end
      MODE_ROT: begin
        p0_d = a;
        q0_d = v;
      end
      MODE_ROT_INV: begin
        p0_d = v;
        q0_d = a;
      end
      default: begin
        p0_d = '0;
        q0_d = '0;
      end
    endcase
    side0_d.mode = s_tuser_i;
    side0_d.ac   = ac;
    side0_d.res  = '0;
    side0_d.sat  = 1'b0;
  end

  assign s0_rdy     = !s0_vld_q || u1_in_ready;
  assign s_tready_o = s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && s_tvalid_i) begin
      s0_p_q    <= p0_d;
      s0_q_q    <= q0_d;
      s0_side_q <= side0_d;
    end
  end

  qmr_qmul u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_vld_q),
    .in_ready_o  (u1_in_ready),
    .p_i         (s0_p_q),
    .q_i         (s0_q_q),
    .want_w_i    (1'b1),
    .side_i      (s0_side_q),
    .out_valid_o (u1_out_valid),
    .out_ready_i (u2_in_ready),
    .r_o         (u1_r),
    .sat_o       (u1_sat),
    .side_o      (u1_side)
  );

  // second product for the rotate modes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = {u1_r[i][DW-1], u1_r[i]};
    end
    if (u1_side.mode == MODE_ROT_INV) begin
      p2 = u1_side.ac;
      q2 = t;
    end else begin
      p2 = t;
      q2 = u1_side.ac;
    end
    side2.mode = u1_side.mode;
    side2.ac   = u1_side.ac;
    side2.res  = u1_r;
    side2.sat  = u1_sat;
  end

  qmr_qmul u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (u1_out_valid),
    .in_ready_o  (u2_in_ready),
    .p_i         (p2),
    .q_i         (q2),
    .want_w_i    (1'b0),
    .side_i      (side2),
    .out_valid_o (u2_out_valid),
    .out_ready_i (out_rdy),
    .r_o         (u2_r),
    .sat_o       (u2_sat),
    .side_o      (u2_side)
  );

  always_comb begin
    case (u2_side.mode)
      MODE_MUL, MODE_CONJ_A, MODE_CONJ_B: begin
        out_r_d   = u2_side.res;
        out_sat_d = u2_side.sat;
      end
      MODE_ROT, MODE_ROT_INV: begin
        out_r_d   = u2_r;
        out_sat_d = u2_side.sat | u2_sat;
      end
      default: begin
        out_r_d   = '0;
        out_sat_d = 1'b0;
      end
    endcase
  end

  assign out_rdy = !out_vld_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= u2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && u2_out_valid) begin
      out_r_q    <= out_r_d;
      out_sat_q  <= out_sat_d;
      out_mode_q <= u2_side.mode;
    end
  end

  assign m_tvalid_o   = out_vld_q;
  assign m_tdata_o    = out_r_q;
  assign m_tuser_o[0] = out_sat_q;

  // unused modes give an all-zero result
  a_unused_mode_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_mode_q > MODE_ROT_INV) |-> (m_tdata_o == '0) && !m_tuser_o[0])
    else $error("unused mode gave a nonzero result");

  // rotations give a pure quaternion
  a_rot_scalar_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_mode_q == MODE_ROT || out_mode_q == MODE_ROT_INV)
      |-> (m_tdata_o[31:0] == '0))
    else $error("rotation result has a nonzero scalar part");

  // input side can only stall when a result is waiting
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("input stalled with an empty output");

endmodule
